// ----- rtl/ctu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ctu_pkg;

  localparam int unsigned WINDOW_DEF = 256;

  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned PEND_W = 9;
  localparam int unsigned FAIL_W = 32;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [PEND_W-1:0] pend_t;
  typedef logic [FAIL_W-1:0] fail_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_WINDOW    = 3'd3,
    ST_CONFLICT  = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_en;    // clearing pass: write zero at the sweep address
    logic accept;    // capture input beat, start slot read
    logic check;     // evaluate slot read for the captured number
    logic walk;      // evaluate one prefix step
    logic out_load;  // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last entry
    logic chk_walk;  // accepted number is the expected head, prefix walks
    logic walk_hit;  // slot of next expected holds it, step again
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ctu_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ctu_in_if;
  logic          valid;
  logic          ready;
  ctu_pkg::seq_t seq_number;

  modport source (output valid, output seq_number, input ready);
  modport sink   (input valid, input seq_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctu_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ctu_out_if;
  logic             valid;
  logic             ready;
  ctu_pkg::status_e status;
  ctu_pkg::seq_t    contiguous_upto;
  ctu_pkg::seq_t    highest_seen;
  ctu_pkg::pend_t   pending_count;
  ctu_pkg::fail_t   failed_count;

  modport source (
    output valid, output status, output contiguous_upto, output highest_seen,
    output pending_count, output failed_count, input ready
  );
  modport sink (
    input valid, input status, input contiguous_upto, input highest_seen,
    input pending_count, input failed_count, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/contiguous_completion_tracker_unit.sv -----
// Timing: an accepted beat is checked in S_CHECK; a reject or an out-of-order accept goes
//   from there to the result register, while an accept of the expected head first walks in
//   S_WALK over the slots it drains after itself (slot RAM read-compare-clear loop, one
//   slot per cycle). A new item is taken only in S_IDLE, once the last result is loaded; a
//   finished result waits in S_DONE while the output register holds an untaken beat.
// Reset: async active low; a clearing pass over all WINDOW slots zeroes the slot RAM, in ready low.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_completion_tracker_unit #(
  parameter int unsigned WINDOW = ctu_pkg::WINDOW_DEF  // power of two, 1..256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ctu_in_if.sink    in_i,
  ctu_out_if.source out_o
);

  // Split: ctu_ctrl sequences the item (clear, accept, check, walk, hand-off),
  // ctu_datapath holds the counters, the slot RAM and the result register.
  ctu_pkg::cmd_t cmd;
  ctu_pkg::sts_t sts;

  ctu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Slot of sequence s is (s-1) mod WINDOW. A slot holds zero when empty.
  // The slot of the next expected number is always empty between items, so
  // only an accept of exactly that number starts a prefix walk.
  ctu_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_seq_i          (in_i.seq_number),
    .status_o          (out_o.status),
    .contiguous_upto_o (out_o.contiguous_upto),
    .highest_seen_o    (out_o.highest_seen),
    .pending_count_o   (out_o.pending_count),
    .failed_count_o    (out_o.failed_count)
  );

endmodule

`default_nettype wire

// ----- rtl/ctu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctu_ram #(
  parameter  int unsigned WIDTH = ctu_pkg::SEQ_W,
  parameter  int unsigned DEPTH = ctu_pkg::WINDOW_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ctu_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ctu_pkg::sts_t sts_i,
  output ctu_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   finish;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    finish  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.chk_walk) begin
          state_d = S_WALK;
        end else begin
          finish = 1'b1;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (!sts_i.walk_hit) begin
          finish = 1'b1;
        end
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // result goes straight to the output register if it is free
    if (finish) begin
      if (out_free) begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end else begin
        state_d = S_DONE;
      end
    end

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted beat not checked next cycle");

endmodule

`default_nettype wire

// ----- rtl/ctu_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctu_datapath #(
  parameter int unsigned WINDOW = ctu_pkg::WINDOW_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ctu_pkg::cmd_t cmd_i,
  output ctu_pkg::sts_t      sts_o,
  input  wire ctu_pkg::seq_t in_seq_i,
  output ctu_pkg::status_e   status_o,
  output ctu_pkg::seq_t      contiguous_upto_o,
  output ctu_pkg::seq_t      highest_seen_o,
  output ctu_pkg::pend_t     pending_count_o,
  output ctu_pkg::fail_t     failed_count_o
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam ctu_pkg::seq_t IdxMask = ctu_pkg::seq_t'(WINDOW - 1);
  localparam ctu_pkg::seq_t WinSpan = ctu_pkg::seq_t'(WINDOW);
  localparam logic [AW-1:0] ClrLast = AW'(WINDOW - 1);

  function automatic logic [AW-1:0] slot_of(input ctu_pkg::seq_t s);
    ctu_pkg::seq_t t;
    t = (s - 64'd1) & IdxMask;
    return t[AW-1:0];
  endfunction

  // tracker state
  ctu_pkg::seq_t    ne_q, ne_d;
  ctu_pkg::seq_t    hi_q, hi_d;
  logic [CW-1:0]    wait_q, wait_d;
  ctu_pkg::fail_t   rej_q, rej_d;
  logic [AW-1:0]    clr_q, clr_d;

  // captured beat and its range flags
  ctu_pkg::seq_t    seq_q, seq_d;
  logic             inv_q, inv_d;
  logic             behind_q, behind_d;
  logic             oow_q, oow_d;
  logic             eqne_q, eqne_d;
  ctu_pkg::status_e st_q, st_d;

  // slot store port
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  ctu_pkg::seq_t    wdata, rdata;

  logic             reject;
  logic             hit;

  ctu_ram #(
    .WIDTH (ctu_pkg::SEQ_W),
    .DEPTH (WINDOW)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign reject = inv_q || behind_q || oow_q || (rdata != '0);
  assign hit    = (rdata == ne_q);

  assign sts_o.clr_last = (clr_q == ClrLast);
  assign sts_o.chk_walk = !reject && eqne_q;
  assign sts_o.walk_hit = hit;

  always_comb begin
    ne_d     = ne_q;
    hi_d     = hi_q;
    wait_d   = wait_q;
    rej_d    = rej_q;
    clr_d    = clr_q;
    seq_d    = seq_q;
    inv_d    = inv_q;
    behind_d = behind_q;
    oow_d    = oow_q;
    eqne_d   = eqne_q;
    st_d     = st_q;
    we       = 1'b0;
    waddr    = slot_of(seq_q);
    wdata    = seq_q;
    re       = 1'b0;
    raddr    = slot_of(in_seq_i);

    if (cmd_i.clr_en) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
      clr_d = clr_q + AW'(1);
    end

    if (cmd_i.accept) begin
      re       = 1'b1;
      raddr    = slot_of(in_seq_i);
      seq_d    = in_seq_i;
      inv_d    = (in_seq_i == '0) || (in_seq_i == '1);
      behind_d = (in_seq_i < ne_q);
      oow_d    = ((in_seq_i - ne_q) >= WinSpan);
      eqne_d   = (in_seq_i == ne_q);
    end

    if (cmd_i.check) begin
      if (reject) begin
        if (rej_q != '1) begin
          rej_d = rej_q + 32'd1;
        end
        if (inv_q) begin
          st_d = ctu_pkg::ST_INVALID;
        end else if (behind_q) begin
          st_d = ctu_pkg::ST_DUPLICATE;
        end else if (oow_q) begin
          st_d = ctu_pkg::ST_WINDOW;
        end else if (rdata == seq_q) begin
          st_d = ctu_pkg::ST_DUPLICATE;
        end else begin
          st_d = ctu_pkg::ST_CONFLICT;
        end
      end else begin
        st_d = ctu_pkg::ST_OK;
        if (hi_q < seq_q) begin
          hi_d = seq_q;
        end
        if (eqne_q) begin
          // head of the prefix: filed and cleared at once, count nets zero
          ne_d  = ne_q + 64'd1;
          re    = 1'b1;
          raddr = slot_of(ne_q + 64'd1);
        end else begin
          // slot of next expected is empty at rest, no walk needed
          we     = 1'b1;
          waddr  = slot_of(seq_q);
          wdata  = seq_q;
          wait_d = wait_q + CW'(1);
        end
      end
    end

    if (cmd_i.walk && hit) begin
      we    = 1'b1;
      waddr = slot_of(ne_q);
      wdata = '0;
      ne_d  = ne_q + 64'd1;
      if (wait_q != '0) begin
        wait_d = wait_q - CW'(1);
      end
      re    = 1'b1;
      raddr = slot_of(ne_q + 64'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q   <= 64'd1;
      hi_q   <= '0;
      wait_q <= '0;
      rej_q  <= '0;
      clr_q  <= '0;
    end else begin
      ne_q   <= ne_d;
      hi_q   <= hi_d;
      wait_q <= wait_d;
      rej_q  <= rej_d;
      clr_q  <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q    <= seq_d;
    inv_q    <= inv_d;
    behind_q <= behind_d;
    oow_q    <= oow_d;
    eqne_q   <= eqne_d;
    st_q     <= st_d;
    if (cmd_i.out_load) begin
      status_o          <= st_d;
      contiguous_upto_o <= ne_d - 64'd1;
      highest_seen_o    <= hi_d;
      pending_count_o   <= ctu_pkg::pend_t'(wait_d);
      failed_count_o    <= rej_d;
    end
  end

  a_wait_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q <= CW'(WINDOW))
    else $error("pending count beyond window");

  a_walk_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk && hit) |-> (ne_q != '1))
    else $error("prefix stepped past the top");

endmodule

`default_nettype wire
